>>> design/es2bcd_pkg.sv
// ----------------------------------------------------------------------------
// es2bcd_pkg: shared types, constants and microcode for the calendar core
// Holds the control word layout, the microprogram, the month-length table
// and the binary to packed-BCD helper.
// ----------------------------------------------------------------------------
package es2bcd_pkg;

  localparam logic [31:0] EPOCH_OFFSET_RST = 32'd946681200;
  localparam logic [15:0] DAYS_PER_BLOCK   = 16'd1461;  // four years, one of them leap
  localparam logic [15:0] DAYS_LEAP_YEAR   = 16'd366;
  localparam logic [15:0] DAYS_YEAR        = 16'd365;
  localparam logic [6:0]  LAST_BLOCK_YEAR  = 7'd96;
  localparam logic [3:0]  LAST_MONTH       = 4'd12;
  localparam logic [3:0]  FEBRUARY         = 4'd2;

  // Reciprocals for the constant divisions. The quotient is the product
  // shifted right by 37, 36 and 34 bits; each is exact for every dividend
  // that reaches it (full 32 bits for 60 and 24, a day count for 7).
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP_7  = 32'h9249_2493;

  typedef logic [3:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_SAVE_SEC,
    OP_SAVE_MIN,
    OP_SAVE_HOUR,
    OP_SAVE_WD,
    OP_YEAR4,
    OP_OVF,
    OP_LEAP,
    OP_YEAR1,
    OP_MONTH,
    OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_OOR,
    C_BLOCK_MORE,
    C_BLOCK_LEFT,
    C_LT_LEAP,
    C_GE_YEAR,
    C_MONTH_MORE
  } cond_t;

  typedef enum logic [1:0] {
    DIV_60,
    DIV_24,
    DIV_7
  } dsel_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_YEAR4 = 4'd9;
  localparam pc_t PC_MONTH = 4'd13;
  localparam pc_t PC_DONE  = 4'd14;

  // The microprogram. A jump is taken when its condition holds before the
  // step's operation updates the datapath.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      4'd0:  w = '{OP_NOP,       DIV_60, C_OOR,        PC_DONE};
      4'd1:  w = '{OP_MUL,       DIV_60, C_NEVER,      4'd0};
      4'd2:  w = '{OP_SAVE_SEC,  DIV_60, C_NEVER,      4'd0};
      4'd3:  w = '{OP_MUL,       DIV_60, C_NEVER,      4'd0};
      4'd4:  w = '{OP_SAVE_MIN,  DIV_60, C_NEVER,      4'd0};
      4'd5:  w = '{OP_MUL,       DIV_24, C_NEVER,      4'd0};
      4'd6:  w = '{OP_SAVE_HOUR, DIV_24, C_NEVER,      4'd0};
      4'd7:  w = '{OP_MUL,       DIV_7,  C_NEVER,      4'd0};
      4'd8:  w = '{OP_SAVE_WD,   DIV_7,  C_NEVER,      4'd0};
      4'd9:  w = '{OP_YEAR4,     DIV_60, C_BLOCK_MORE, PC_YEAR4};
      4'd10: w = '{OP_OVF,       DIV_60, C_BLOCK_LEFT, PC_DONE};
      4'd11: w = '{OP_LEAP,      DIV_60, C_LT_LEAP,    PC_MONTH};
      4'd12: w = '{OP_YEAR1,     DIV_60, C_GE_YEAR,    4'd12};
      4'd13: w = '{OP_MONTH,     DIV_60, C_MONTH_MORE, PC_MONTH};
      4'd14: w = '{OP_FINISH,    DIV_60, C_NEVER,      4'd0};
      default: w = '{OP_NOP,     DIV_60, C_ALWAYS,     PC_DONE};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Values up to 99 only.
  function automatic logic [7:0] to_bcd(logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) tens = 4'(k);
    end
    ones = v - 7'(tens * 10);
    return {tens, ones[3:0]};
  endfunction

endpackage

>>> design/epoch_seconds_to_bcd_calendar_core.sv
// An input below the offset jumps from the first step to the final one; any
// other runs four reciprocal-multiply divisions (by 60, 60, 24 and 7) of two
// steps each, up to 25 four-year steps, 3 single-year steps, 12 month steps.
// One item is worked at a time; the next is accepted as soon as the result is
// registered, even if that result is still stalled. Reset (rst_n low, sync)
// restores the default epoch offset and empties the sequencer and output.
// ----------------------------------------------------------------------------
// epoch_seconds_to_bcd_calendar_core
// Converts a seconds count into packed-BCD time, date and day of week using a
// microcoded sequencer that drives a reciprocal multiplier and day-walking datapath.
// ----------------------------------------------------------------------------
module epoch_seconds_to_bcd_calendar_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_bcd_second,
  output logic [7:0]  out_bcd_minute,
  output logic [7:0]  out_bcd_hour,
  output logic [2:0]  out_weekday,
  output logic [7:0]  out_bcd_day,
  output logic [7:0]  out_bcd_month,
  output logic [7:0]  out_bcd_year,
  output logic        out_out_of_range
);
  import es2bcd_pkg::*;

  logic [31:0] offset_r, offset_nxt;
  logic        busy_r, busy_nxt;
  logic        ovalid_r, ovalid_nxt;
  pc_t         pc_r, pc_nxt;
  logic [31:0] t_r, t_nxt;
  logic [29:0] prod_r, prod_nxt;
  logic        oor_r, oor_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [2:0]  wd_r, wd_nxt;
  logic [15:0] days_r, days_nxt;
  logic [6:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic        leap_r, leap_nxt;

  logic [6:0]  o_sec_r, o_sec_nxt;
  logic [7:0]  o_min_r, o_min_nxt;
  logic [7:0]  o_hour_r, o_hour_nxt;
  logic [2:0]  o_wd_r, o_wd_nxt;
  logic [7:0]  o_day_r, o_day_nxt;
  logic [7:0]  o_month_r, o_month_nxt;
  logic [7:0]  o_year_r, o_year_nxt;
  logic        o_oor_r, o_oor_nxt;

  uword_t      uw;
  logic        in_take;
  logic        exec;
  logic        taken;
  logic [5:0]  divisor;
  logic [31:0] recip;
  logic [63:0] prod_full;
  logic [31:0] quot;
  logic [5:0]  qd_lo;
  logic [5:0]  rem_lo;
  logic [15:0] mlen;
  logic        block_more;
  logic        month_more;
  logic [3:0]  wd_sum;
  logic [3:0]  wd_mod;
  logic [7:0]  bcd_sec;

  assign uw        = ucode(pc_r);
  assign in_stall  = busy_r;
  assign in_take   = in_valid && !busy_r;
  assign cfg_ready = !busy_r;
  // The final step waits while the previous result is still held downstream.
  assign exec      = busy_r && !(uw.op == OP_FINISH && ovalid_r && out_stall);

  always_comb begin
    case (uw.dsel)
      DIV_60: begin
        divisor = 6'd60;
        recip   = RECIP_60;
      end
      DIV_24: begin
        divisor = 6'd24;
        recip   = RECIP_24;
      end
      DIV_7: begin
        divisor = 6'd7;
        recip   = RECIP_7;
      end
      default: begin
        divisor = 6'd60;
        recip   = RECIP_60;
      end
    endcase
  end

  // Only the upper 30 bits of the product are kept; the quotient is a
  // further shift of those that depends on the divisor.
  assign prod_full = 64'(t_r) * 64'(recip);

  always_comb begin
    case (uw.dsel)
      DIV_60:  quot = {5'd0, prod_r[29:3]};
      DIV_24:  quot = {4'd0, prod_r[29:2]};
      DIV_7:   quot = {2'd0, prod_r};
      default: quot = {5'd0, prod_r[29:3]};
    endcase
  end

  // Every remainder is below 64, so the low six bits are enough.
  assign qd_lo      = quot[5:0] * divisor;
  assign rem_lo     = t_r[5:0] - qd_lo;
  assign mlen       = {11'd0, month_len(month_r)} +
                      {15'd0, leap_r && (month_r == FEBRUARY)};
  assign block_more = (days_r >= DAYS_PER_BLOCK) && (year_r != LAST_BLOCK_YEAR);
  assign month_more = (month_r != LAST_MONTH) && (days_r >= mlen);
  // Day 0 of the count is a Saturday; rotate so that Monday maps to 1.
  assign wd_sum     = {1'b0, rem_lo[2:0]} + 4'd5;
  assign wd_mod     = (wd_sum >= 4'd7) ? wd_sum - 4'd7 : wd_sum;
  assign bcd_sec    = to_bcd({1'b0, sec_r});

  always_comb begin
    case (uw.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_OOR:        taken = oor_r;
      C_BLOCK_MORE: taken = block_more;
      C_BLOCK_LEFT: taken = days_r >= DAYS_PER_BLOCK;
      C_LT_LEAP:    taken = days_r < DAYS_LEAP_YEAR;
      C_GE_YEAR:    taken = days_r >= DAYS_YEAR;
      C_MONTH_MORE: taken = month_more;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    offset_nxt  = offset_r;
    busy_nxt    = busy_r;
    ovalid_nxt  = ovalid_r;
    pc_nxt      = pc_r;
    t_nxt       = t_r;
    prod_nxt    = prod_r;
    oor_nxt     = oor_r;
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    hour_nxt    = hour_r;
    wd_nxt      = wd_r;
    days_nxt    = days_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    leap_nxt    = leap_r;
    o_sec_nxt   = o_sec_r;
    o_min_nxt   = o_min_r;
    o_hour_nxt  = o_hour_r;
    o_wd_nxt    = o_wd_r;
    o_day_nxt   = o_day_r;
    o_month_nxt = o_month_r;
    o_year_nxt  = o_year_r;
    o_oor_nxt   = o_oor_r;

    if (cfg_valid && cfg_ready) begin
      offset_nxt = cfg_data;
    end
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    if (in_take) begin
      t_nxt    = in_epoch_seconds - offset_r;
      oor_nxt  = in_epoch_seconds < offset_r;
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (exec) begin
      pc_nxt = taken ? uw.target : pc_r + 4'd1;
      case (uw.op)
        OP_MUL: begin
          prod_nxt = prod_full[63:34];
        end
        OP_SAVE_SEC: begin
          sec_nxt = rem_lo;
          t_nxt   = quot;
        end
        OP_SAVE_MIN: begin
          min_nxt = rem_lo;
          t_nxt   = quot;
        end
        OP_SAVE_HOUR: begin
          hour_nxt = rem_lo[4:0];
          days_nxt = quot[15:0];
          t_nxt    = quot;
        end
        OP_SAVE_WD: begin
          wd_nxt    = wd_mod[2:0] + 3'd1;
          year_nxt  = '0;
          month_nxt = 4'd1;
        end
        OP_YEAR4: begin
          if (block_more) begin
            days_nxt = days_r - DAYS_PER_BLOCK;
            year_nxt = year_r + 7'd4;
          end
        end
        OP_OVF: begin
          oor_nxt = days_r >= DAYS_PER_BLOCK;
        end
        OP_LEAP: begin
          if (days_r >= DAYS_LEAP_YEAR) begin
            days_nxt = days_r - DAYS_LEAP_YEAR;
            year_nxt = year_r + 7'd1;
            leap_nxt = 1'b0;
          end else begin
            leap_nxt = 1'b1;
          end
        end
        OP_YEAR1: begin
          if (days_r >= DAYS_YEAR) begin
            days_nxt = days_r - DAYS_YEAR;
            year_nxt = year_r + 7'd1;
          end
        end
        OP_MONTH: begin
          if (month_more) begin
            days_nxt  = days_r - mlen;
            month_nxt = month_r + 4'd1;
          end
        end
        OP_FINISH: begin
          busy_nxt   = 1'b0;
          ovalid_nxt = 1'b1;
          o_oor_nxt  = oor_r;
          if (oor_r) begin
            o_sec_nxt   = '0;
            o_min_nxt   = '0;
            o_hour_nxt  = '0;
            o_wd_nxt    = '0;
            o_day_nxt   = '0;
            o_month_nxt = '0;
            o_year_nxt  = '0;
          end else begin
            o_sec_nxt   = bcd_sec[6:0];
            o_min_nxt   = to_bcd({1'b0, min_r});
            o_hour_nxt  = to_bcd({2'b00, hour_r});
            o_wd_nxt    = wd_r;
            o_day_nxt   = to_bcd(days_r[6:0] + 7'd1);
            o_month_nxt = to_bcd({3'b000, month_r});
            o_year_nxt  = to_bcd(year_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= EPOCH_OFFSET_RST;
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      pc_r     <= '0;
    end else begin
      offset_r <= offset_nxt;
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      pc_r     <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    prod_r    <= prod_nxt;
    oor_r     <= oor_nxt;
    sec_r     <= sec_nxt;
    min_r     <= min_nxt;
    hour_r    <= hour_nxt;
    wd_r      <= wd_nxt;
    days_r    <= days_nxt;
    year_r    <= year_nxt;
    month_r   <= month_nxt;
    leap_r    <= leap_nxt;
    o_sec_r   <= o_sec_nxt;
    o_min_r   <= o_min_nxt;
    o_hour_r  <= o_hour_nxt;
    o_wd_r    <= o_wd_nxt;
    o_day_r   <= o_day_nxt;
    o_month_r <= o_month_nxt;
    o_year_r  <= o_year_nxt;
    o_oor_r   <= o_oor_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_bcd_second   = o_sec_r;
  assign out_bcd_minute   = o_min_r;
  assign out_bcd_hour     = o_hour_r;
  assign out_weekday      = o_wd_r;
  assign out_bcd_day      = o_day_r;
  assign out_bcd_month    = o_month_r;
  assign out_bcd_year     = o_year_r;
  assign out_out_of_range = o_oor_r;

endmodule
